### hdl/mmos_pkg.sv
// Shared constants, codes and control structs for the matrix multiply/scale core.
`timescale 1ns / 1ps
package mmos_pkg;

  localparam int MAX_DIM_DEF     = 8;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int DATA_W    = 32;  // element and result width
  localparam int FRAC_W    = 16;  // Q16.16 fraction bits
  localparam int POS_W     = 3;   // row / column field width
  localparam int CNT_W     = 4;   // dimension register width
  localparam int CFG_IDX_W = 2;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int TDATA_W   = 40;
  localparam int PAD_W     = TDATA_W - 2 * POS_W - DATA_W;

  localparam logic [CNT_W-1:0] CNT_RESET = 4'd8;

  // input command codes (tuser)
  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  // result status codes (tuser)
  localparam logic [STAT_W-1:0] ST_PRODUCT = 2'd0;
  localparam logic [STAT_W-1:0] ST_SCALE   = 2'd1;
  localparam logic [STAT_W-1:0] ST_ERROR   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic              first;
    logic              last_term;
    logic              emit_en;
    logic              emit_err;
    logic              emit_last;
    logic [STAT_W-1:0] emit_status;
    logic [POS_W-1:0]  emit_row;
    logic [POS_W-1:0]  emit_col;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_done;
    logic out_free;
  } dp_stat_t;

endpackage

### hdl/matrix_multiply_or_scale_core.sv
// Top level: dimension registers, controller and datapath of the matrix core.
//
//   port group      dir  handshake             payload
//   s_axis_*        in   tvalid/tready         tdata: row, col, value; tuser: command
//   m_axis_*        out  tvalid/tready         tdata: row, col, value; tuser: status; tlast
//   cfg_*           in   cfg_we_i              cfg_idx_i, cfg_data_i
//
// Load items go straight into a store. A compute item runs its terms for each result
// through the single shared MAC and its registered store read, terms being A's column
// count for a product and 1 for scaling. A mismatch gives a single error item.
// Reset clears control state only; the stores hold nothing useful until loaded.
// A stalled output holds the run; loads are taken while the last result waits.
`timescale 1ns / 1ps
module matrix_multiply_or_scale_core import mmos_pkg::*; #(
  parameter int MAX_DIM     = MAX_DIM_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [TDATA_W-1:0]   s_axis_tdata_i,   // row_index[2:0], col_index[5:3],
                                                 // element_value[37:6]
  input  logic [CMD_W-1:0]     s_axis_tuser_i,   // command[1:0]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [TDATA_W-1:0]   m_axis_tdata_o,   // out_row[2:0], out_col[5:3], out_value[37:6]
  output logic [STAT_W-1:0]    m_axis_tuser_o,   // status[1:0]
  output logic                 m_axis_tlast_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  localparam int AW = $clog2(MAX_DIM * MAX_DIM);

  logic [CNT_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  dp_cmd_t          dp_cmd;
  dp_stat_t         dp_stat;
  logic [AW-1:0]    wr_addr, a_raddr, b_raddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= CNT_RESET;
      a_cols_q <= CNT_RESET;
      b_rows_q <= CNT_RESET;
      b_cols_q <= CNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_A_ROWS: a_rows_q <= cfg_data_i;
        REG_A_COLS: a_cols_q <= cfg_data_i;
        REG_B_ROWS: b_rows_q <= cfg_data_i;
        REG_B_COLS: b_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mmos_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .command_i (s_axis_tuser_i),
    .row_i     (s_axis_tdata_i[POS_W-1:0]),
    .col_i     (s_axis_tdata_i[2*POS_W-1:POS_W]),
    .value_i   (s_axis_tdata_i[2*POS_W+DATA_W-1:2*POS_W]),
    .a_rows_i  (a_rows_q),
    .a_cols_i  (a_cols_q),
    .b_rows_i  (b_rows_q),
    .b_cols_i  (b_cols_q),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd),
    .wr_addr_o (wr_addr),
    .a_raddr_o (a_raddr),
    .b_raddr_o (b_raddr)
  );

  mmos_datapath #(
    .MAX_DIM     (MAX_DIM),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .wr_addr_i       (wr_addr),
    .a_raddr_i       (a_raddr),
    .b_raddr_i       (b_raddr),
    .stat_o          (dp_stat),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

`ifndef SYNTH
  // a result is only loaded into a free output slot
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.emit_en |-> dp_stat.out_free)
    else $error("result loaded over a pending output item");

  // the MAC finishes only while a compute run holds off the input
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_stat.acc_done |-> !s_axis_tready_o)
    else $error("accumulator finished outside a compute run");

  // a mismatch item is a lone zero result
  a_err_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == ST_ERROR) |->
      (m_axis_tlast_o && m_axis_tdata_o == '0))
    else $error("malformed mismatch item");

  // compute reads of the stores never coincide with a store write
  a_rd_no_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.rd_en |-> !(dp_cmd.wr_a || dp_cmd.wr_b))
    else $error("store write during a compute read");
`endif

endmodule

### hdl/mmos_datapath.sv
// Datapath: A/B element stores, shared multiply-accumulate and output register.
`timescale 1ns / 1ps
module mmos_datapath import mmos_pkg::*; #(
  parameter int MAX_DIM     = MAX_DIM_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int AW         = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [AW-1:0]      a_raddr_i,
  input  logic [AW-1:0]      b_raddr_i,
  output dp_stat_t           stat_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o,  // out_row[2:0], out_col[5:3], out_value[37:6]
  output logic [STAT_W-1:0]  m_axis_tuser_o,  // status[1:0]
  output logic               m_axis_tlast_o
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);
  localparam int SAT_W  = (VALUE_WIDTH > DATA_W) ? DATA_W : VALUE_WIDTH;
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W - SAT_W + 1){1'b0}}, {(SAT_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

  logic [DATA_W-1:0] a_mem [DEPTH];
  logic [DATA_W-1:0] b_mem [DEPTH];

  logic signed [DATA_W-1:0] a_rd_q, b_rd_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [ACC_W-1:0]  clipped;
  logic [DATA_W-1:0]        res_val;

  logic s1_vld_q, s1_first_q, s1_last_q;
  logic s2_vld_q, s2_first_q, s2_last_q;
  logic done_q;

  logic               tvalid_q;
  logic [TDATA_W-1:0] tdata_q;
  logic [STAT_W-1:0]  tuser_q;
  logic               tlast_q;

  // stores: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      a_mem[wr_addr_i] <= cmd_i.wr_data;
    end
    a_rd_q <= a_mem[a_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_b) begin
      b_mem[wr_addr_i] <= cmd_i.wr_data;
    end
    b_rd_q <= b_mem[b_raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_vld_q   <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_vld_q   <= cmd_i.rd_en;
      s1_first_q <= cmd_i.first;
      s1_last_q  <= cmd_i.last_term;
      s2_vld_q   <= s1_vld_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      done_q     <= s2_vld_q & s2_last_q;
    end
  end

  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      prod_q <= a_rd_q * b_rd_q;
    end
    if (s2_vld_q) begin
      acc_q <= s2_first_q ? prod_ext : acc_q + prod_ext;
    end
  end

  // exact sum, floor shift, then clip to the result range
  always_comb begin
    shifted = acc_q >>> FRAC_W;
    if (shifted > SAT_MAX) begin
      clipped = SAT_MAX;
    end else if (shifted < SAT_MIN) begin
      clipped = SAT_MIN;
    end else begin
      clipped = shifted;
    end
    res_val = cmd_i.emit_err ? '0 : clipped[DATA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (cmd_i.emit_en) begin
      tvalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_en) begin
      tdata_q <= {{PAD_W{1'b0}}, res_val, cmd_i.emit_col, cmd_i.emit_row};
      tuser_q <= cmd_i.emit_status;
      tlast_q <= cmd_i.emit_last;
    end
  end

  assign stat_o.acc_done = done_q;
  assign stat_o.out_free = !tvalid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = tvalid_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;
  assign m_axis_tlast_o  = tlast_q;

endmodule

### hdl/mmos_ctrl.sv
// Controller: command decode, mode selection and row/column/term sequencing.
`timescale 1ns / 1ps
module mmos_ctrl import mmos_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  localparam int AW     = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [POS_W-1:0]  row_i,
  input  logic [POS_W-1:0]  col_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [CNT_W-1:0]  a_rows_i,
  input  logic [CNT_W-1:0]  a_cols_i,
  input  logic [CNT_W-1:0]  b_rows_i,
  input  logic [CNT_W-1:0]  b_cols_i,
  input  dp_stat_t          stat_i,
  output dp_cmd_t           cmd_o,
  output logic [AW-1:0]     wr_addr_o,
  output logic [AW-1:0]     a_raddr_o,
  output logic [AW-1:0]     b_raddr_o
);

  localparam int IW = $clog2(MAX_DIM);
  localparam int CW = $clog2(MAX_DIM + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  function automatic logic [CW-1:0] clamp_dim(logic [CNT_W-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = CW'(MAX_DIM);
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] elem_addr(logic [IW-1:0] r, logic [IW-1:0] c);
    return AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  logic [1:0]        state_q, state_d;
  logic [STAT_W-1:0] mode_q, mode_d;
  logic [CW-1:0]     rows_q, rows_d;
  logic [CW-1:0]     cols_q, cols_d;
  logic [CW-1:0]     terms_q, terms_d;
  logic [IW-1:0]     i_q, i_d;
  logic [IW-1:0]     j_q, j_d;
  logic [IW-1:0]     t_q, t_d;

  logic [CW-1:0] ar, ac, br, bc;
  logic          load_ok, t_last, i_last, j_last, run_last;

  assign ar = clamp_dim(a_rows_i);
  assign ac = clamp_dim(a_cols_i);
  assign br = clamp_dim(b_rows_i);
  assign bc = clamp_dim(b_cols_i);

  // loads outside the store are dropped
  assign load_ok  = (int'(row_i) < MAX_DIM) && (int'(col_i) < MAX_DIM);
  assign t_last   = (CW'(t_q) + CW'(1)) == terms_q;
  assign i_last   = (CW'(i_q) + CW'(1)) == rows_q;
  assign j_last   = (CW'(j_q) + CW'(1)) == cols_q;
  assign run_last = (mode_q == ST_ERROR) || (i_last && j_last);

  assign s_ready_o = (state_q == S_IDLE);
  assign wr_addr_o = AW'(int'(row_i) * MAX_DIM + int'(col_i));

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    rows_d    = rows_q;
    cols_d    = cols_q;
    terms_d   = terms_q;
    i_d       = i_q;
    j_d       = j_q;
    t_d       = t_q;
    cmd_o     = '0;
    cmd_o.wr_data     = value_i;
    cmd_o.emit_status = mode_q;
    cmd_o.emit_row    = POS_W'(i_q);
    cmd_o.emit_col    = POS_W'(j_q);
    cmd_o.emit_err    = (mode_q == ST_ERROR);
    cmd_o.emit_last   = run_last;
    a_raddr_o = elem_addr(i_q, t_q);
    b_raddr_o = elem_addr(t_q, j_q);

    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          case (command_i)
            CMD_LOAD_A: cmd_o.wr_a = load_ok;
            CMD_LOAD_B: cmd_o.wr_b = load_ok;
            CMD_COMPUTE: begin
              i_d    = '0;
              j_d    = '0;
              t_d    = '0;
              rows_d = ar;
              if (ac == br) begin
                mode_d  = ST_PRODUCT;
                cols_d  = bc;
                terms_d = ac;
                state_d = S_ISSUE;
              end else if (br == CW'(1) && bc == CW'(1)) begin
                mode_d  = ST_SCALE;
                cols_d  = ac;
                terms_d = CW'(1);
                state_d = S_ISSUE;
              end else begin
                mode_d  = ST_ERROR;
                state_d = S_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.first     = (t_q == '0);
        cmd_o.last_term = t_last;
        if (mode_q == ST_SCALE) begin
          a_raddr_o = elem_addr(i_q, j_q);
          b_raddr_o = '0;
        end
        if (t_last) begin
          t_d     = '0;
          state_d = S_WAIT;
        end else begin
          t_d = t_q + IW'(1);
        end
      end
      S_WAIT: begin
        if (stat_i.acc_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_en = 1'b1;
          if (run_last) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_ISSUE;
            if (j_last) begin
              j_d = '0;
              i_d = i_q + IW'(1);
            end else begin
              j_d = j_q + IW'(1);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= ST_PRODUCT;
      rows_q  <= CW'(1);
      cols_q  <= CW'(1);
      terms_q <= CW'(1);
      i_q     <= '0;
      j_q     <= '0;
      t_q     <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      rows_q  <= rows_d;
      cols_q  <= cols_d;
      terms_q <= terms_d;
      i_q     <= i_d;
      j_q     <= j_d;
      t_q     <= t_d;
    end
  end

endmodule

### tb/sv/mmos_result_checker.sv
// Checker for the matrix core: predicts result runs from observed items and compares.
`timescale 1ns / 1ps
module mmos_result_checker import mmos_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  logic                 s_ready_i,
  input  logic [TDATA_W-1:0]   s_data_i,   // row_index[2:0], col_index[5:3],
                                           // element_value[37:6]
  input  logic [CMD_W-1:0]     s_user_i,   // command[1:0]
  input  logic                 m_valid_i,
  input  logic                 m_ready_i,
  input  logic [TDATA_W-1:0]   m_data_i,   // out_row[2:0], out_col[5:3], out_value[37:6]
  input  logic [STAT_W-1:0]    m_user_i,   // status[1:0]
  input  logic                 m_last_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  output int                   err_cnt_o,
  output int                   pend_o
);

  localparam int DIM = MAX_DIM_DEF;

  typedef struct {
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic [STAT_W-1:0] status;
    logic              last;
  } mat_result_t;

  mat_result_t      expected_q[$];
  logic [DATA_W-1:0] a_mem [DIM*DIM];
  logic [DATA_W-1:0] b_mem [DIM*DIM];
  logic [CNT_W-1:0] a_rows, a_cols, b_rows, b_cols;
  int               mismatches;

  assign err_cnt_o = mismatches;

  function automatic int eff_dim(logic [CNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  // floor shift of the exact sum, then clamp to 32-bit signed
  function automatic logic [DATA_W-1:0] q16_saturate(logic signed [71:0] acc);
    logic signed [71:0] q;
    q = acc >>> FRAC_W;
    if (q > $signed(72'd2147483647)) return 32'h7FFF_FFFF;
    if (q < -$signed(72'd2147483648)) return 32'h8000_0000;
    return q[DATA_W-1:0];
  endfunction

  task automatic predict_run();
    int ar, ac, br, bc;
    logic signed [71:0] acc;
    logic signed [63:0] prod;
    logic signed [31:0] x, y;
    mat_result_t r;
    ar = eff_dim(a_rows);
    ac = eff_dim(a_cols);
    br = eff_dim(b_rows);
    bc = eff_dim(b_cols);
    if (ac == br) begin
      for (int i = 0; i < ar; i++) begin
        for (int j = 0; j < bc; j++) begin
          acc = '0;
          for (int t = 0; t < ac; t++) begin
            x = a_mem[i*DIM+t];
            y = b_mem[t*DIM+j];
            prod = x * y;
            acc = acc + prod;
          end
          r.row    = POS_W'(i);
          r.col    = POS_W'(j);
          r.value  = q16_saturate(acc);
          r.status = ST_PRODUCT;
          r.last   = (i == ar - 1) && (j == bc - 1);
          expected_q.insert(expected_q.size(), r);
        end
      end
    end else if (br == 1 && bc == 1) begin
      y = b_mem[0];
      for (int i = 0; i < ar; i++) begin
        for (int j = 0; j < ac; j++) begin
          x = a_mem[i*DIM+j];
          prod = x * y;
          acc = prod;
          r.row    = POS_W'(i);
          r.col    = POS_W'(j);
          r.value  = q16_saturate(acc);
          r.status = ST_SCALE;
          r.last   = (i == ar - 1) && (j == ac - 1);
          expected_q.insert(expected_q.size(), r);
        end
      end
    end else begin
      r.row    = '0;
      r.col    = '0;
      r.value  = '0;
      r.status = ST_ERROR;
      r.last   = 1'b1;
      expected_q.insert(expected_q.size(), r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int n_push, n_pop, pos;
    mat_result_t exp_r;
    logic [POS_W-1:0] got_row, got_col;
    logic [DATA_W-1:0] got_val;
    if (!rst_ni) begin
      a_rows     <= CNT_RESET;
      a_cols     <= CNT_RESET;
      b_rows     <= CNT_RESET;
      b_cols     <= CNT_RESET;
      pend_o     <= 0;
      mismatches = 0;
      expected_q.delete();
    end else begin
      n_push = 0;
      n_pop  = 0;
      // results leaving belong to an earlier run than any compute item taken now
      if (m_valid_i && m_ready_i) begin
        got_row = m_data_i[POS_W-1:0];
        got_col = m_data_i[2*POS_W-1:POS_W];
        got_val = m_data_i[2*POS_W+DATA_W-1:2*POS_W];
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result: row %0d col %0d value %h status %0d last %0b",
                     $realtime, got_row, got_col, got_val, m_user_i, m_last_i);
        end else begin
          exp_r = expected_q.pop_front();
          n_pop = 1;
          if (got_row !== exp_r.row || got_col !== exp_r.col ||
              got_val !== exp_r.value || m_user_i !== exp_r.status ||
              m_last_i !== exp_r.last || m_data_i[TDATA_W-1:2*POS_W+DATA_W] !== '0) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result mismatch", $realtime);
              $display("  expected: row %0d col %0d value %h status %0d last %0b",
                       exp_r.row, exp_r.col, exp_r.value, exp_r.status, exp_r.last);
              $display("  actual:   row %0d col %0d value %h status %0d last %0b pad %b",
                       got_row, got_col, got_val, m_user_i, m_last_i,
                       m_data_i[TDATA_W-1:2*POS_W+DATA_W]);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_A_ROWS: a_rows <= cfg_data_i;
          REG_A_COLS: a_cols <= cfg_data_i;
          REG_B_ROWS: b_rows <= cfg_data_i;
          REG_B_COLS: b_cols <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        pos = int'(s_data_i[POS_W-1:0]) * DIM + int'(s_data_i[2*POS_W-1:POS_W]);
        case (s_user_i)
          CMD_LOAD_A: a_mem[pos] = s_data_i[2*POS_W+DATA_W-1:2*POS_W];
          CMD_LOAD_B: b_mem[pos] = s_data_i[2*POS_W+DATA_W-1:2*POS_W];
          CMD_COMPUTE: begin
            n_push = expected_q.size();
            predict_run();
            n_push = expected_q.size() - n_push;
          end
          default: ;  // unknown command is dropped
        endcase
      end
      pend_o <= pend_o + n_push - n_pop;
    end
  end

endmodule

### tb/sv/tb_matrix_multiply_or_scale_core.sv
// Testbench top for the matrix core: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps
module tb_matrix_multiply_or_scale_core;
  import mmos_pkg::*;

  localparam int DIM          = MAX_DIM_DEF;
  localparam int N_RANDOM     = 85;
  localparam int HOLD_PHASE   = 3;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_valid;
  logic                 s_ready;
  logic [TDATA_W-1:0]   s_data;    // row_index[2:0], col_index[5:3], element_value[37:6]
  logic [CMD_W-1:0]     s_user;    // command[1:0]
  logic                 m_valid;
  logic                 m_ready;
  logic [TDATA_W-1:0]   m_data;    // out_row[2:0], out_col[5:3], out_value[37:6]
  logic [STAT_W-1:0]    m_user;    // status[1:0]
  logic                 m_last;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CNT_W-1:0]     cfg_data;
  int                   err_cnt;
  int                   pend;

  // stimulus-side bookkeeping
  logic [DIM*DIM-1:0] a_written, b_written;
  int                 ar, ac, br, bc;
  int                 work_items;
  bit                 calm;
  logic               quiet;
  int                 hold_reqs;
  int                 idle_cycles;

  always #4 clk_i = ~clk_i;

  matrix_multiply_or_scale_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  mmos_result_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_valid),
    .s_ready_i  (s_ready),
    .s_data_i   (s_data),
    .s_user_i   (s_user),
    .m_valid_i  (m_valid),
    .m_ready_i  (m_ready),
    .m_data_i   (m_data),
    .m_user_i   (m_user),
    .m_last_i   (m_last),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .err_cnt_o  (err_cnt),
    .pend_o     (pend)
  );

  function automatic int eff_dim(int v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5: begin
        // small magnitudes keep sums away from saturation
        v = $urandom_range(0, 32'h0004_0000);
        return $urandom_range(0, 1) ? (~v + 1'b1) : v;
      end
      default: return $urandom();
    endcase
  endfunction

  // called at a clock step; returns at the step where the item is taken
  task automatic put_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] row,
                          input logic [POS_W-1:0] col, input logic [DATA_W-1:0] val);
    if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= {{PAD_W{1'b0}}, val, col, row};
    do @(posedge clk_i); while (!s_ready);
    if (cmd != CMD_UNUSED) work_items++;
    if (cmd == CMD_LOAD_A) a_written[row*DIM+col] = 1'b1;
    if (cmd == CMD_LOAD_B) b_written[row*DIM+col] = 1'b1;
  endtask

  // all results in, then a margin for a load still in flight
  task automatic wait_idle();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pend != 0);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_dims(input int ra, input int ca, input int rb, input int cb);
    cfg_we <= 1'b1; cfg_idx <= REG_A_ROWS; cfg_data <= CNT_W'(ra);
    @(posedge clk_i);
    cfg_idx <= REG_A_COLS; cfg_data <= CNT_W'(ca);
    @(posedge clk_i);
    cfg_idx <= REG_B_ROWS; cfg_data <= CNT_W'(rb);
    @(posedge clk_i);
    cfg_idx <= REG_B_COLS; cfg_data <= CNT_W'(cb);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    ar = eff_dim(ra);
    ac = eff_dim(ca);
    br = eff_dim(rb);
    bc = eff_dim(cb);
  endtask

  // load one needed entry, sometimes behind a stray item
  task automatic load_entry(input bit to_b, input int r, input int c);
    logic written;
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1))
        put_item(CMD_UNUSED, POS_W'($urandom()), POS_W'($urandom()), $urandom());
      else
        put_item($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A, POS_W'($urandom()),
                 POS_W'($urandom()), pick_value());
    end
    written = to_b ? b_written[r*DIM+c] : a_written[r*DIM+c];
    if (!written || $urandom_range(0, 1))
      put_item(to_b ? CMD_LOAD_B : CMD_LOAD_A, POS_W'(r), POS_W'(c), pick_value());
  endtask

  task automatic run_phase(input bit with_hold);
    calm = ($urandom_range(0, 3) == 0);
    if (ac == br) begin
      for (int i = 0; i < ar; i++)
        for (int t = 0; t < ac; t++) load_entry(1'b0, i, t);
      for (int t = 0; t < ac; t++)
        for (int j = 0; j < bc; j++) load_entry(1'b1, t, j);
    end else if (br == 1 && bc == 1) begin
      for (int i = 0; i < ar; i++)
        for (int j = 0; j < ac; j++) load_entry(1'b0, i, j);
      load_entry(1'b1, 0, 0);
    end else begin
      repeat ($urandom_range(0, 2))
        put_item($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A, POS_W'($urandom()),
                 POS_W'($urandom()), pick_value());
    end
    if (with_hold) hold_reqs <= hold_reqs + 1;
    put_item(CMD_COMPUTE, POS_W'($urandom()), POS_W'($urandom()), $urandom());
  endtask

  task automatic pick_dims();
    int r[4];
    int kind, idx;
    foreach (r[k]) r[k] = $urandom_range(0, 3);
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      idx = $urandom_range(0, 3);
      r[idx] = $urandom_range(0, 1) ? DIM : $urandom_range(DIM + 1, 15);
    end
    if (kind >= 2 && kind <= 5) begin
      r[2] = r[1];
    end else if (kind == 6 || kind == 7) begin
      r[1] = $urandom_range(2, 3);
      r[2] = $urandom_range(0, 1);
      r[3] = $urandom_range(0, 1);
    end
    set_dims(r[0], r[1], r[2], r[3]);
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int hold_seen;
    bit busy;
    hold_seen = 0;
    busy      = 1'b1;
    m_ready   = 1'b0;
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) busy = !busy;
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (busy && !quiet && $urandom_range(0, 3) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        m_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int base_items, phase_no;
    bit reconf;
    rst_ni      = 1'b0;
    s_valid     = 1'b0;
    s_data      = '0;
    s_user      = CMD_LOAD_A;
    cfg_we      = 1'b0;
    cfg_idx     = REG_A_ROWS;
    cfg_data    = '0;
    quiet       = 1'b0;
    hold_reqs   = 0;
    idle_cycles = 0;
    a_written   = '0;
    b_written   = '0;
    work_items  = 0;
    calm        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: positive saturation of a two-term dot product, then a stray command
    set_dims(1, 2, 2, 1);
    put_item(CMD_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
    put_item(CMD_LOAD_A, 3'd0, 3'd1, 32'h7FFF_FFFF);
    put_item(CMD_LOAD_B, 3'd0, 3'd0, 32'h8000_0000);
    put_item(CMD_LOAD_B, 3'd1, 3'd0, 32'h7FFF_FFFF);
    put_item(CMD_COMPUTE, 3'd0, 3'd0, 32'h0);
    put_item(CMD_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
    // scaling by 1.0: the smallest negative value must come back unchanged
    wait_idle();
    set_dims(1, 2, 1, 1);
    put_item(CMD_LOAD_B, 3'd0, 3'd0, 32'h0001_0000);
    put_item(CMD_LOAD_A, 3'd0, 3'd0, 32'hFFFF_FFFF);
    put_item(CMD_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);
    // zero counts act as one: 1x1 product with negative saturation
    wait_idle();
    set_dims(0, 0, 0, 0);
    put_item(CMD_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
    put_item(CMD_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
    put_item(CMD_COMPUTE, 3'd0, 3'd0, 32'h0);
    // dimension mismatch, plus loads at the far corner
    wait_idle();
    set_dims(1, 3, 2, 2);
    put_item(CMD_LOAD_A, 3'd7, 3'd7, 32'h0);
    put_item(CMD_LOAD_B, 3'd7, 3'd7, 32'hFFFF_FFFF);
    put_item(CMD_COMPUTE, 3'd0, 3'd0, 32'h0);
    // oversized row count acts as full height
    wait_idle();
    set_dims(15, 1, 0, 1);
    run_phase(1'b0);

    base_items = work_items;
    phase_no   = 0;
    while (work_items < base_items + N_RANDOM || phase_no <= HOLD_PHASE + 2) begin
      // the two phases after the hold-off keep offering items to a stalled block
      reconf = (phase_no == 0) ||
               (phase_no != HOLD_PHASE + 1 && phase_no != HOLD_PHASE + 2 &&
                $urandom_range(0, 2) != 0);
      if (reconf) begin
        wait_idle();
        pick_dims();
      end
      if (!quiet && work_items >= base_items + N_RANDOM - 25) quiet <= 1'b1;
      run_phase(phase_no == HOLD_PHASE);
      phase_no++;
    end

    wait_idle();
    repeat (32) @(posedge clk_i);
    if (err_cnt == 0 && pend == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
